>>> hw/rtl/skt_pkg.sv
package skt_pkg;

  // Table geometry
  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Field widths
  localparam int CMD_W  = 3;
  localparam int KEY_W  = 32;
  localparam int ST_W   = 3;

  // Stream beat widths, rounded up to whole bytes
  localparam int IN_BITS  = CMD_W + 3 * KEY_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ST_W + 2 * KEY_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_SEARCH = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_LIST   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_REPLY,
    S_LIST
  } state_t;

  // Pending single-beat reply
  typedef enum logic [2:0] {
    R_FULL,
    R_MISS,
    R_HIT,
    R_DUP,
    R_NEW,
    R_UPD,
    R_CLEAR,
    R_EMPTY
  } reply_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_USED
  } idx_op_t;

  typedef enum logic [1:0] {
    USED_HOLD,
    USED_INC,
    USED_CLR
  } used_op_t;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_NEW,
    SRC_HIT,
    SRC_UPD,
    SRC_ENTRY
  } out_src_t;

  typedef enum logic [1:0] {
    WR_MOVE,
    WR_NEW,
    WR_UPD
  } wr_src_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    idx_op_t  idx_op;
    logic     rd_prev;
    logic     pos_ld;
    logic     mem_we;
    wr_src_t  wr_src;
    used_op_t used_op;
    logic     emit;
    out_src_t out_src;
    status_t  status;
    logic     last;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic used_zero;
    logic used_full;
    logic idx_at_used;
    logic idx_at_pos;
    logic key_gt;
    logic key_eq;
    logic list_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/skt_ctrl.sv
module skt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  skt_pkg::sts_t st,
  output skt_pkg::ctl_t ctl
);
  import skt_pkg::*;

  state_t state, state_next;
  reply_t reply, reply_next;

  // State and pending reply registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reply <= R_CLEAR;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    reply_next = reply;
    ctl        = '0;
    s_tready   = 1'b0;

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load_in = 1'b1;
          ctl.idx_op  = IDX_ZERO;
          state_next  = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (st.cmd) inside
          CMD_INSERT: begin
            if (st.used_full) begin
              reply_next = R_FULL;
              state_next = S_REPLY;
            end else begin
              state_next = S_SCAN;
            end
          end
          CMD_SEARCH, CMD_UPDATE: state_next = S_SCAN;
          CMD_LIST: begin
            if (st.used_zero) begin
              reply_next = R_EMPTY;
              state_next = S_REPLY;
            end else begin
              state_next = S_LIST;
            end
          end
          CMD_CLEAR: begin
            ctl.used_op = USED_CLR;
            reply_next  = R_CLEAR;
            state_next  = S_REPLY;
          end
          default: state_next = S_IDLE;
        endcase
      end

      // Walk up to the first entry whose key is not below the search key
      S_SCAN: begin
        if (st.idx_at_used || !st.key_gt) begin
          state_next = S_REPLY;
          unique case (st.cmd) inside
            CMD_INSERT: begin
              if (!st.idx_at_used && st.key_eq) begin
                reply_next = R_DUP;
              end else begin
                ctl.pos_ld  = 1'b1;
                ctl.idx_op  = IDX_USED;
                ctl.rd_prev = 1'b1;
                state_next  = S_SHIFT;
              end
            end
            CMD_SEARCH: reply_next = (!st.idx_at_used && st.key_eq) ? R_HIT : R_MISS;
            CMD_UPDATE: reply_next = (!st.idx_at_used && st.key_eq) ? R_UPD : R_MISS;
            default:    state_next = S_IDLE;
          endcase
        end else begin
          ctl.idx_op = IDX_INC;
        end
      end

      // Move entries up one slot from the top down, then drop in the new one
      S_SHIFT: begin
        ctl.mem_we = 1'b1;
        if (st.idx_at_pos) begin
          ctl.wr_src  = WR_NEW;
          ctl.used_op = USED_INC;
          reply_next  = R_NEW;
          state_next  = S_REPLY;
        end else begin
          ctl.wr_src  = WR_MOVE;
          ctl.idx_op  = IDX_DEC;
          ctl.rd_prev = 1'b1;
        end
      end

      S_REPLY: begin
        if (st.out_free) begin
          ctl.emit   = 1'b1;
          ctl.last   = 1'b1;
          state_next = S_IDLE;
          unique case (reply)
            R_FULL:  begin ctl.out_src = SRC_ZERO; ctl.status = ST_FULL;      end
            R_MISS:  begin ctl.out_src = SRC_ZERO; ctl.status = ST_NOT_FOUND; end
            R_HIT:   begin ctl.out_src = SRC_HIT;  ctl.status = ST_OK;        end
            R_DUP:   begin ctl.out_src = SRC_HIT;  ctl.status = ST_DUPLICATE; end
            R_NEW:   begin ctl.out_src = SRC_NEW;  ctl.status = ST_OK;        end
            R_UPD: begin
              ctl.out_src = SRC_UPD;
              ctl.status  = ST_OK;
              ctl.mem_we  = 1'b1;
              ctl.wr_src  = WR_UPD;
            end
            R_CLEAR: begin ctl.out_src = SRC_ZERO; ctl.status = ST_OK;        end
            R_EMPTY: begin ctl.out_src = SRC_ZERO; ctl.status = ST_EMPTY;     end
            default: begin ctl.out_src = SRC_ZERO; ctl.status = ST_OK;        end
          endcase
        end
      end

      // One entry per beat in key order
      S_LIST: begin
        if (st.out_free) begin
          ctl.emit    = 1'b1;
          ctl.out_src = SRC_ENTRY;
          ctl.status  = ST_OK;
          ctl.last    = st.list_last;
          if (st.list_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.idx_op = IDX_INC;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/skt_dp.sv
module skt_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [skt_pkg::IN_W-1:0]  s_tdata,
  input  skt_pkg::ctl_t             ctl,
  output skt_pkg::sts_t             st,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [skt_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);
  import skt_pkg::*;

  // Captured item
  cmd_t                     cmd_r;
  logic signed [KEY_W-1:0]  key_r;
  logic        [KEY_W-1:0]  start_r;
  logic        [KEY_W-1:0]  delta_r;

  // Walk index, insert position and fill count
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] rd_sel;
  logic [IDX_W-1:0] rd_addr;

  // Entry store, single write and single registered read port
  logic signed [KEY_W-1:0] mem_key [CAPACITY];
  logic        [KEY_W-1:0] mem_cnt [CAPACITY];
  logic signed [KEY_W-1:0] rd_key;
  logic        [KEY_W-1:0] rd_cnt;
  logic signed [KEY_W-1:0] wr_key;
  logic        [KEY_W-1:0] wr_cnt;
  logic        [KEY_W-1:0] upd_sum;

  // Output register
  status_t          out_status;
  logic [KEY_W-1:0] out_key;
  logic [KEY_W-1:0] out_cnt;
  logic [CNT_W:0]   idx_inc;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r   <= cmd_t'(s_tdata[CMD_W-1:0]);
      key_r   <= s_tdata[CMD_W +: KEY_W];
      start_r <= s_tdata[CMD_W+KEY_W +: KEY_W];
      delta_r <= s_tdata[CMD_W+2*KEY_W +: KEY_W];
    end
  end

  // Index update
  always_comb begin
    case (ctl.idx_op)
      IDX_ZERO: idx_next = '0;
      IDX_INC:  idx_next = idx + CNT_W'(1);
      IDX_DEC:  idx_next = idx - CNT_W'(1);
      IDX_USED: idx_next = used;
      default:  idx_next = idx;
    endcase
  end

  // Read address follows the next index, or the slot below it while shifting
  assign rd_sel  = ctl.rd_prev ? (idx_next - CNT_W'(1)) : idx_next;
  assign rd_addr = rd_sel[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      used <= '0;
    end else begin
      idx <= idx_next;
      case (ctl.used_op)
        USED_INC: used <= used + CNT_W'(1);
        USED_CLR: used <= '0;
        default:  used <= used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pos_ld) begin
      pos <= idx;
    end
  end

  // Store write data
  assign upd_sum = rd_cnt + delta_r;

  always_comb begin
    case (ctl.wr_src)
      WR_NEW: begin
        wr_key = key_r;
        wr_cnt = start_r;
      end
      WR_UPD: begin
        wr_key = rd_key;
        wr_cnt = upd_sum;
      end
      default: begin
        wr_key = rd_key;
        wr_cnt = rd_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem_key[idx[IDX_W-1:0]] <= wr_key;
      mem_cnt[idx[IDX_W-1:0]] <= wr_cnt;
    end
    rd_key <= mem_key[rd_addr];
    rd_cnt <= mem_cnt[rd_addr];
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status <= ctl.status;
      m_tlast    <= ctl.last;
      case (ctl.out_src)
        SRC_NEW: begin
          out_key <= key_r;
          out_cnt <= start_r;
        end
        SRC_HIT: begin
          out_key <= key_r;
          out_cnt <= rd_cnt;
        end
        SRC_UPD: begin
          out_key <= key_r;
          out_cnt <= upd_sum;
        end
        SRC_ENTRY: begin
          out_key <= rd_key;
          out_cnt <= rd_cnt;
        end
        default: begin
          out_key <= '0;
          out_cnt <= '0;
        end
      endcase
    end
  end

  assign m_tdata = {(OUT_W - OUT_BITS)'(0), out_cnt, out_key, out_status};

  // Status back to the controller
  assign idx_inc = {1'b0, idx} + (CNT_W + 1)'(1);

  assign st.cmd         = cmd_r;
  assign st.used_zero   = (used == '0);
  assign st.used_full   = (32'(used) >= CAPACITY);
  assign st.idx_at_used = (idx == used);
  assign st.idx_at_pos  = (idx == pos);
  assign st.key_gt      = (key_r > rd_key);
  assign st.key_eq      = (key_r == rd_key);
  assign st.list_last   = (idx_inc == {1'b0, used}) || (32'(idx_inc) >= MAX_RESULTS);
  assign st.out_free    = !m_tvalid || m_tready;

endmodule

>>> hw/rtl/sorted_keyed_table_core.sv
// Sorted key/count table: up to CAPACITY entries held in ascending signed-key order in
// an entry store with one read and one write port that is walked one entry per cycle.
// One command is taken at a time. Search and update walk to the entry's place;
// insert walks to the position, then moves the entries above it up one slot;
// list gives one beat per entry; clear, a full-table insert and an empty list
// reply without a walk. The store needs no clearing pass after reset. The result
// register lets the next command be taken while a result beat is still waiting.
module sorted_keyed_table_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // command[2:0], part_key[34:3], start_count[66:35], delta[98:67], zero pad
  input  logic [skt_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[2:0], entry_key[34:3], entry_count[66:35], zero pad
  output logic [skt_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);
  import skt_pkg::*;

  ctl_t ctl;
  sts_t st;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .ctl      (ctl)
  );

  skt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .ctl      (ctl),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // Never overwrite a result beat that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> st.out_free)
    else $error("result register loaded over a pending beat");

  // An empty-table status is always a single, final beat
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[ST_W-1:0] == ST_EMPTY) |-> m_tlast)
    else $error("empty status without last");

  // One command in flight: accepting a beat closes the input side
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command accepted while busy");
`endif

endmodule

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int BATCH_ITEMS  = 112;
  localparam int POOL_SIZE    = 40;
  localparam int MAX_GAP      = 8;
  localparam int PRINT_CAP    = 50;

  // command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] ALL_ONES = 32'hffff_ffff;

  // one command beat plus an optional hand-written expectation
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] start;
    logic [KEY_W-1:0] delta;
    logic             fixed_exp;
    status_t          exp_status;
    logic [KEY_W-1:0] exp_key;
    logic [KEY_W-1:0] exp_count;
  } table_cmd_t;

  // one result beat
  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] count;
    logic             last;
  } table_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  // mirror of the table contents
  logic signed [KEY_W-1:0] mirror_key   [CAPACITY];
  logic        [KEY_W-1:0] mirror_count [CAPACITY];
  int                      mirror_used = 0;

  table_result_t pending_results [$];
  table_result_t step_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int  err_count   = 0;
  int  beat_count  = 0;
  int  cycle_count = 0;
  bit  fast_sender = 1'b0;
  bit  fast_sink   = 1'b0;

  always #CLK_HALF clk = ~clk;

  sorted_keyed_table_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  task automatic flag_error(input string msg);
    if (err_count < PRINT_CAP) begin
      $display("ERROR beat %0d: %s", beat_count, msg);
    end
    err_count++;
  endtask

  function automatic table_cmd_t row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                     input logic [KEY_W-1:0] start,
                                     input logic [KEY_W-1:0] delta,
                                     input logic fixed_exp = 1'b0,
                                     input status_t exp_status = ST_OK,
                                     input logic [KEY_W-1:0] exp_key = '0,
                                     input logic [KEY_W-1:0] exp_count = '0);
    table_cmd_t r;
    r.cmd        = cmd;
    r.key        = key;
    r.start      = start;
    r.delta      = delta;
    r.fixed_exp  = fixed_exp;
    r.exp_status = exp_status;
    r.exp_key    = exp_key;
    r.exp_count  = exp_count;
    return r;
  endfunction

  function automatic void add_result(input status_t st, input logic [KEY_W-1:0] k,
                                     input logic [KEY_W-1:0] c, input logic l);
    table_result_t r;
    r.status = st;
    r.key    = k;
    r.count  = c;
    r.last   = l;
    step_results.push_back(r);
  endfunction

  // Table predictor: updates the mirror and leaves this command's beats in step_results
  task automatic apply_table_cmd(input logic [CMD_W-1:0] cmd,
                                 input logic signed [KEY_W-1:0] key,
                                 input logic [KEY_W-1:0] start,
                                 input logic [KEY_W-1:0] delta);
    int  pos;
    int  i;
    int  n;
    bit  hit;
    step_results.delete();
    // lower bound: first slot whose key is not below the command key
    pos = 0;
    while (pos < mirror_used && key > mirror_key[pos]) pos++;
    hit = (pos < mirror_used) && (mirror_key[pos] == key);
    case (cmd)
      CMD_INSERT: begin
        // a full table wins over a duplicate key
        if (mirror_used >= CAPACITY) begin
          add_result(ST_FULL, '0, '0, 1'b1);
        end else if (hit) begin
          add_result(ST_DUPLICATE, key, mirror_count[pos], 1'b1);
        end else begin
          for (i = mirror_used; i > pos; i--) begin
            mirror_key[i]   = mirror_key[i-1];
            mirror_count[i] = mirror_count[i-1];
          end
          mirror_key[pos]   = key;
          mirror_count[pos] = start;
          mirror_used++;
          add_result(ST_OK, key, start, 1'b1);
        end
      end
      CMD_SEARCH: begin
        if (hit) add_result(ST_OK, key, mirror_count[pos], 1'b1);
        else add_result(ST_NOT_FOUND, '0, '0, 1'b1);
      end
      CMD_UPDATE: begin
        if (hit) begin
          mirror_count[pos] = mirror_count[pos] + delta;
          add_result(ST_OK, key, mirror_count[pos], 1'b1);
        end else begin
          add_result(ST_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        n = (mirror_used > MAX_RESULTS) ? MAX_RESULTS : mirror_used;
        if (n == 0) add_result(ST_EMPTY, '0, '0, 1'b1);
        for (i = 0; i < n; i++) begin
          add_result(ST_OK, mirror_key[i], mirror_count[i], i == n - 1);
        end
      end
      CMD_CLEAR: begin
        mirror_used = 0;
        add_result(ST_OK, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Drive one command beat; valid stays high after the handshake until the next call
  task automatic send_item(input table_cmd_t it);
    int gap;
    table_result_t r;
    gap = fast_sender ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-IN_BITS){1'b0}}, it.delta, it.start, it.key, it.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_table_cmd(it.cmd, it.key, it.start, it.delta);
    if (it.fixed_exp) begin
      r.status = it.exp_status;
      r.key    = it.exp_key;
      r.count  = it.exp_count;
      r.last   = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Hold off the sender until every outstanding beat has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Mixed random traffic on a small key pool so hits, duplicates and full all occur
  task automatic random_batch(input int n_items);
    int counted;
    int r;
    logic [CMD_W-1:0] cmd;
    counted = 0;
    while (counted < n_items) begin
      r = $urandom_range(0, 95);
      if (r < 38) cmd = CMD_INSERT;
      else if (r < 60) cmd = CMD_SEARCH;
      else if (r < 82) cmd = CMD_UPDATE;
      else if (r < 90) cmd = CMD_LIST;
      else if (r < 92) cmd = CMD_CLEAR;
      else cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      if ($urandom_range(0, 31) == 0) fast_sender = ~fast_sender;
      if ($urandom_range(0, 49) == 0) wait_drained();
      send_item(row(cmd, pick_key(), $urandom, $urandom));
      if (cmd < CMD_UNUSED_LO) counted++;
    end
  endtask

  // Fill the table to capacity, push past it, list all entries, update and search some, list again
  task automatic fill_table_run();
    int k;
    wait_drained();
    send_item(row(CMD_CLEAR, $urandom, $urandom, $urandom));
    for (k = 0; k < CAPACITY + 3; k++) begin
      send_item(row(CMD_INSERT, $urandom, $urandom, $urandom));
    end
    // existing key on a full table reports full
    send_item(row(CMD_INSERT, mirror_key[$urandom_range(0, mirror_used - 1)], $urandom,
                  $urandom));
    send_item(row(CMD_LIST, $urandom, $urandom, $urandom));
    for (k = 0; k < 6; k++) begin
      send_item(row(CMD_UPDATE, mirror_key[$urandom_range(0, mirror_used - 1)], $urandom,
                    $urandom));
      send_item(row(CMD_SEARCH, mirror_key[$urandom_range(0, mirror_used - 1)], $urandom,
                    $urandom));
    end
    send_item(row(CMD_LIST, $urandom, $urandom, $urandom));
  endtask

  // Result side: random back-pressure and in-order compare
  initial begin : result_sink
    int stall;
    table_result_t want;
    logic [ST_W-1:0]  got_status;
    logic [KEY_W-1:0] got_key;
    logic [KEY_W-1:0] got_count;
    stall = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_status = m_tdata[ST_W-1:0];
        got_key    = m_tdata[ST_W +: KEY_W];
        got_count  = m_tdata[ST_W+KEY_W +: KEY_W];
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected beat status %0d key %h", got_status, got_key));
        end else begin
          want = pending_results.pop_front();
          if (got_status !== want.status)
            flag_error($sformatf("status %0d, want %0d", got_status, want.status));
          if (got_key !== want.key)
            flag_error($sformatf("entry_key %h, want %h", got_key, want.key));
          if (got_count !== want.count)
            flag_error($sformatf("entry_count %h, want %h", got_count, want.count));
          if (m_tlast !== want.last)
            flag_error($sformatf("tlast %b, want %b", m_tlast, want.last));
        end
        beat_count++;
        stall = fast_sink ? 0 : $urandom_range(0, MAX_GAP);
      end else if (stall > 0) begin
        stall--;
      end
      if ($urandom_range(0, 63) == 0) fast_sink = ~fast_sink;
      m_tready <= (stall == 0);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    table_cmd_t directed [$];
    int k;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;

    // key pool: extremes first, then random keys
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = ALL_ONES;
    key_pool[4] = 32'd1;
    for (k = 5; k < POOL_SIZE; k++) key_pool[k] = $urandom;

    // directed table: key extremes, wrap, every status but full, ignored codes
    directed.push_back(row(CMD_LIST, '0, '0, '0, 1'b1, ST_EMPTY));
    directed.push_back(row(CMD_SEARCH, KEY_MIN, '0, '0, 1'b1, ST_NOT_FOUND));
    directed.push_back(row(CMD_UPDATE, KEY_MAX, '0, 32'd5, 1'b1, ST_NOT_FOUND));
    directed.push_back(row(CMD_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, ST_OK));
    directed.push_back(row(CMD_INSERT, KEY_MIN, KEY_MAX, '0, 1'b1, ST_OK, KEY_MIN, KEY_MAX));
    directed.push_back(row(CMD_INSERT, KEY_MAX, KEY_MIN, '0, 1'b1, ST_OK, KEY_MAX, KEY_MIN));
    directed.push_back(row(CMD_INSERT, '0, '0, ALL_ONES, 1'b1, ST_OK, '0, '0));
    directed.push_back(row(CMD_INSERT, ALL_ONES, ALL_ONES, '0, 1'b1, ST_OK, ALL_ONES,
                           ALL_ONES));
    directed.push_back(row(CMD_INSERT, 32'd1, 32'h1234_5678, '0, 1'b1, ST_OK, 32'd1,
                           32'h1234_5678));
    directed.push_back(row(CMD_INSERT, KEY_MIN, 32'd7, '0, 1'b1, ST_DUPLICATE, KEY_MIN,
                           KEY_MAX));
    directed.push_back(row(CMD_SEARCH, KEY_MAX, '0, '0, 1'b1, ST_OK, KEY_MAX, KEY_MIN));
    directed.push_back(row(CMD_UPDATE, KEY_MAX, '0, KEY_MAX, 1'b1, ST_OK, KEY_MAX, ALL_ONES));
    directed.push_back(row(CMD_UPDATE, KEY_MIN, '0, 32'd1, 1'b1, ST_OK, KEY_MIN, KEY_MIN));
    directed.push_back(row(CMD_UPDATE, ALL_ONES, '0, ALL_ONES));
    directed.push_back(row(CMD_UPDATE, 32'd2, '0, 32'd9, 1'b1, ST_NOT_FOUND));
    directed.push_back(row(CMD_SEARCH, '0, ALL_ONES, ALL_ONES, 1'b1, ST_OK, '0, '0));
    directed.push_back(row(CMD_UNUSED_LO, '0, '0, '0));
    directed.push_back(row(CMD_UNUSED_MID, KEY_MIN, KEY_MIN, KEY_MIN));
    directed.push_back(row(CMD_UNUSED_HI, ALL_ONES, ALL_ONES, ALL_ONES));
    directed.push_back(row(CMD_LIST, '0, '0, '0));
    directed.push_back(row(CMD_CLEAR, '0, '0, '0, 1'b1, ST_OK));
    directed.push_back(row(CMD_LIST, '0, '0, '0, 1'b1, ST_EMPTY));
    directed.push_back(row(CMD_SEARCH, KEY_MIN, '0, '0, 1'b1, ST_NOT_FOUND));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i]);
    wait_drained();

    // random traffic with two capacity runs in between
    for (k = 0; k < 3; k++) begin
      random_batch(BATCH_ITEMS);
      if (k < 2) fill_table_run();
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_ctrl.sv
hw/rtl/skt_dp.sv
hw/rtl/sorted_keyed_table_core.sv
sim/testbench.sv
